// ===== hdl/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg: shared definitions for the one-wire bus master
// Phase and command codes, register map, timing defaults, the CRC-8 fold
// and the structs passed between the top level and the sequencer core.
// ----------------------------------------------------------------------------
package owbm_pkg;

    // widths of the timing registers and the phase timer
    localparam int TIMER_W = 11;
    localparam int SHORT_W = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int PHASE_W = 3;

    // released ticks ahead of a reset pulse
    localparam int unsigned RESET_IDLE_TICKS_DEF = 100;

    // bus phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RST_IDLE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RST_LOW = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RST_WAIT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SLOT_LOW = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SLOT_HIGH = 3'd5;

    // request kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ONE_LOW = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ZERO_LOW = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_TIME = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_SAMPLE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_RECOVERY = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_LOW = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_SAMPLE_DELAY = 3'd7;

    // reflected Maxim polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef struct packed {
        logic [SHORT_W-1:0] write_one_low_time;
        logic [SHORT_W-1:0] write_zero_low_time;
        logic [SHORT_W-1:0] slot_time;
        logic [TIMER_W-1:0] reset_low_time;
        logic [TIMER_W-1:0] presence_sample_time;
        logic [TIMER_W-1:0] reset_recovery_time;
        logic [SHORT_W-1:0] read_low_time;
        logic [SHORT_W-1:0] read_sample_delay;
    } cfg_t;

    localparam cfg_t CFG_DEFAULT = '{
        write_one_low_time: 8'd3,
        write_zero_low_time: 8'd70,
        slot_time: 8'd80,
        reset_low_time: 11'd1000,
        presence_sample_time: 11'd70,
        reset_recovery_time: 11'd500,
        read_low_time: 8'd3,
        read_sample_delay: 8'd12
    };

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       rejected;
        logic       presence;
        logic [7:0] read_data;
        logic [7:0] crc_value;
    } result_t;

    // a zero duration counts as one tick
    function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
        at_least_one = (v == '0) ? TIMER_W'(1) : v;
    endfunction

    // fold one byte into the running crc, lsb first
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_fold = c;
    endfunction

endpackage

// ===== hdl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master with Maxim CRC-8 on read bytes
// Tick and command requests go through an input register, the sequencer
// step and a result register; timing registers set the slot and reset shape.
// ----------------------------------------------------------------------------
// Each request is a one-microsecond tick or a reset, write-byte or
// read-byte command, and each yields exactly one result with the bus drive,
// busy, done, reject and presence flags plus the last read byte and crc.
// The block takes one request per clock unless the result stalls, and its
// result passes through the input register and the result register; the
// sequencer step between them is a single pass of logic. A stalled result
// holds the pipeline, and the input register absorbs one more request.
// The user must write timing registers only while no request is outstanding;
// the block does not enforce it. Commands during an operation are rejected.
module one_wire_bus_master #(
    parameter int unsigned RESET_IDLE_TICKS = owbm_pkg::RESET_IDLE_TICKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          kind,
    input  logic [7:0]                          data_byte,
    input  logic                                line_level,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                drive_low,
    output logic                                busy_res,
    output logic                                done_res,
    output logic                                rejected,
    output logic                                presence,
    output logic [7:0]                          read_data,
    output logic [7:0]                          crc_value
);
    import owbm_pkg::*;

    cfg_t       cfg_reg;
    logic       item_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] data_byte_reg;
    logic       line_level_reg;
    logic       out_valid_reg;
    result_t    res_reg;
    result_t    step_res;
    logic       advance;
    logic       load;

    // pipeline flow control
    assign advance = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign load = in_valid && !in_stall;

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_DEFAULT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WRITE_ONE_LOW:     cfg_reg.write_one_low_time <= cfg_data[SHORT_W-1:0];
                REG_WRITE_ZERO_LOW:    cfg_reg.write_zero_low_time <= cfg_data[SHORT_W-1:0];
                REG_SLOT_TIME:         cfg_reg.slot_time <= cfg_data[SHORT_W-1:0];
                REG_RESET_LOW:         cfg_reg.reset_low_time <= cfg_data;
                REG_PRESENCE_SAMPLE:   cfg_reg.presence_sample_time <= cfg_data;
                REG_RESET_RECOVERY:    cfg_reg.reset_recovery_time <= cfg_data;
                REG_READ_LOW:          cfg_reg.read_low_time <= cfg_data[SHORT_W-1:0];
                REG_READ_SAMPLE_DELAY: cfg_reg.read_sample_delay <= cfg_data[SHORT_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind;
            data_byte_reg <= data_byte;
            line_level_reg <= line_level;
        end
    end

    // sequencer
    owbm_core #(
        .RESET_IDLE_TICKS(RESET_IDLE_TICKS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .kind       (kind_reg),
        .data_byte  (data_byte_reg),
        .line_level (line_level_reg),
        .cfg        (cfg_reg),
        .res        (step_res)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_low = res_reg.drive_low;
    assign busy_res = res_reg.busy;
    assign done_res = res_reg.done;
    assign rejected = res_reg.rejected;
    assign presence = res_reg.presence;
    assign read_data = res_reg.read_data;
    assign crc_value = res_reg.crc_value;

endmodule

// ===== hdl/owbm_core.sv =====
// ----------------------------------------------------------------------------
// owbm_core: one-wire sequencer state and step logic
// Holds the bus phase, timer, shift byte and crc, and works out the next
// state and the result for one request in a single pass.
// ----------------------------------------------------------------------------
module owbm_core #(
    parameter int unsigned RESET_IDLE_TICKS = owbm_pkg::RESET_IDLE_TICKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [1:0]        kind,
    input  logic [7:0]        data_byte,
    input  logic              line_level,
    input  owbm_pkg::cfg_t    cfg,
    output owbm_pkg::result_t res
);
    import owbm_pkg::*;

    localparam logic [TIMER_W-1:0] IDLE_TICKS = TIMER_W'(RESET_IDLE_TICKS);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [7:0]         shift_reg, shift_next;
    logic [2:0]         bit_index_reg, bit_index_next;
    logic               reading_reg, reading_next;
    logic [7:0]         crc_reg, crc_next;
    logic               presence_reg, presence_next;
    logic [7:0]         last_read_reg, last_read_next;

    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] slot_low;
    logic [TIMER_W-1:0] sample_at;
    logic [TIMER_W-1:0] slot_len;
    logic [7:0]         shift_tmp;
    logic               done;
    logic               rejected;

    // slot timing derived from the current state
    assign timer_inc = timer_reg + TIMER_W'(1);
    assign slot_low = reading_reg ? at_least_one(TIMER_W'(cfg.read_low_time))
                    : at_least_one(TIMER_W'(shift_reg[0] ? cfg.write_one_low_time
                                                         : cfg.write_zero_low_time));
    assign sample_at = slot_low + TIMER_W'(cfg.read_sample_delay);
    assign slot_len = at_least_one(TIMER_W'(cfg.slot_time));

    // next state for one request
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        bit_index_next = bit_index_reg;
        reading_next = reading_reg;
        crc_next = crc_reg;
        presence_next = presence_reg;
        last_read_next = last_read_reg;
        shift_tmp = shift_reg;
        done = 1'b0;
        rejected = 1'b0;
        if (kind == KIND_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                timer_next = timer_inc;
                case (phase_reg)
                    PH_RST_IDLE:
                    begin
                        if (timer_inc >= IDLE_TICKS)
                        begin
                            phase_next = PH_RST_LOW;
                            timer_next = '0;
                        end
                    end
                    PH_RST_LOW:
                    begin
                        if (timer_inc >= at_least_one(cfg.reset_low_time))
                        begin
                            phase_next = PH_RST_WAIT;
                            timer_next = '0;
                        end
                    end
                    PH_RST_WAIT:
                    begin
                        if (timer_inc == at_least_one(cfg.presence_sample_time))
                        begin
                            presence_next = ~line_level;
                        end
                        if (timer_inc >= at_least_one(cfg.reset_recovery_time))
                        begin
                            phase_next = PH_IDLE;
                            timer_next = '0;
                            done = 1'b1;
                        end
                    end
                    default:
                    begin
                        // bit slot: low part, then released part
                        if (phase_reg == PH_SLOT_LOW && timer_inc >= slot_low)
                        begin
                            phase_next = PH_SLOT_HIGH;
                        end
                        if (phase_next == PH_SLOT_HIGH && reading_reg &&
                            timer_inc == sample_at)
                        begin
                            shift_tmp = {line_level, shift_reg[7:1]};
                        end
                        shift_next = shift_tmp;
                        if (phase_reg == PH_SLOT_HIGH && timer_inc >= slot_len &&
                            (!reading_reg || timer_inc >= sample_at))
                        begin
                            if (!reading_reg)
                            begin
                                shift_next = {1'b0, shift_tmp[7:1]};
                            end
                            timer_next = '0;
                            if (bit_index_reg == 3'd7)
                            begin
                                bit_index_next = 3'd0;
                                phase_next = PH_IDLE;
                                done = 1'b1;
                                if (reading_reg)
                                begin
                                    last_read_next = shift_tmp;
                                    crc_next = crc_fold(crc_reg, shift_tmp);
                                end
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + 3'd1;
                                phase_next = PH_SLOT_LOW;
                            end
                        end
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            rejected = 1'b1;
        end
        else
        begin
            timer_next = '0;
            bit_index_next = 3'd0;
            if (kind == KIND_RESET)
            begin
                phase_next = PH_RST_IDLE;
                reading_next = 1'b0;
                crc_next = 8'd0;
                presence_next = 1'b0;
            end
            else
            begin
                phase_next = PH_SLOT_LOW;
                reading_next = (kind == KIND_READ);
                shift_next = (kind == KIND_READ) ? 8'd0 : data_byte;
            end
        end
    end

    // result seen after this request
    always_comb
    begin
        res.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);
        res.busy = (phase_next != PH_IDLE);
        res.done = done;
        res.rejected = rejected;
        res.presence = presence_next;
        res.read_data = last_read_next;
        res.crc_value = crc_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            shift_reg <= '0;
            bit_index_reg <= '0;
            reading_reg <= 1'b0;
            crc_reg <= '0;
            presence_reg <= 1'b0;
            last_read_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            shift_reg <= shift_next;
            bit_index_reg <= bit_index_next;
            reading_reg <= reading_next;
            crc_reg <= crc_next;
            presence_reg <= presence_next;
            last_read_reg <= last_read_next;
        end
    end

`ifndef SYNTH
    // a finished operation leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> phase_reg == PH_IDLE)
        else $error("owbm_core: not idle after done");

    // only a request arriving mid-operation is turned away
    assert property (@(posedge clk) disable iff (!rst_n)
        step && rejected |-> phase_reg != PH_IDLE && phase_next == phase_reg)
        else $error("owbm_core: reject while idle or phase moved");

    // bit counter and timer rest at zero between operations
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> bit_index_reg == 3'd0 && timer_reg == '0)
        else $error("owbm_core: counters not cleared while idle");

    // the crc only moves on a completed read or a reset start
    assert property (@(posedge clk) disable iff (!rst_n)
        step && crc_next != crc_reg |-> (done && reading_reg) || kind == KIND_RESET)
        else $error("owbm_core: crc changed unexpectedly");
`endif

endmodule
